[hdl/rbh_pkg.sv]
package rbh_pkg;

    localparam int CHANNELS    = 32;
    localparam int BINS        = 4096;
    localparam int COUNT_WIDTH = 32;

    localparam int DEPTH  = CHANNELS * BINS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int BIN_W  = $clog2(BINS);
    localparam int IDX_W  = 12;
    localparam int STAT_W = 3;

    localparam logic [BIN_W-1:0] BIN_OVER = BIN_W'(BINS - 4);
    localparam logic [BIN_W-1:0] BIN_NEG  = BIN_W'(BINS - 2);

    localparam logic [STAT_W-1:0] ST_BINNED  = 3'd0;
    localparam logic [STAT_W-1:0] ST_OVER    = 3'd1;
    localparam logic [STAT_W-1:0] ST_NEG     = 3'd2;
    localparam logic [STAT_W-1:0] ST_IGNORED = 3'd3;
    localparam logic [STAT_W-1:0] ST_READ    = 3'd4;

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    typedef enum logic [1:0] {
        OP_INC  = 2'd0,
        OP_READ = 2'd1,
        OP_ZERO = 2'd2
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [ADDR_W-1:0]  addr;
        logic [IDX_W-1:0]   idx;
        logic [STAT_W-1:0]  status;
    } t_cmd;

endpackage

[hdl/ratio_binned_histogram.sv]
// Reads, ignored items and items clamped by sign or zero divisor go from the front straight
// into the command queue; items that need the ratio first pass the 32-step serial divider
// and a rounding step. The back end then reads the bin and registers the result.
// The front takes one item at a time and holds o_full until its command enters the queue.
// Reset is synchronous and active low; afterwards a clearing pass zeroes all CHANNELS*BINS
// (131072) entries of the bin store, one entry per cycle, with o_full held high.
module ratio_binned_histogram (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    output logic                o_full,
    input  logic                i_func,
    input  logic [4:0]          i_channel,
    input  logic signed [31:0]  i_fit_chisq,
    input  logic [15:0]         i_fit_dof,
    input  logic [11:0]         i_read_bin,
    output logic                o_empty,
    input  logic                i_pop,
    output logic [11:0]         o_bin_index,
    output logic [31:0]         o_bin_count,
    output logic [2:0]          o_status
);

    rbh_pkg::t_cmd front_cmd;
    rbh_pkg::t_cmd head_cmd;
    logic          front_full;
    logic          cmd_push;
    logic          cmd_full;
    logic          cmd_pop;
    logic          cmd_empty;
    logic          clearing;

    assign o_full = front_full || clearing;

    rbh_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push && !clearing),
        .i_func      (i_func),
        .i_channel   (i_channel),
        .i_fit_chisq (i_fit_chisq),
        .i_fit_dof   (i_fit_dof),
        .i_read_bin  (i_read_bin),
        .o_full      (front_full),
        .o_cmd       (front_cmd),
        .o_cmd_push  (cmd_push),
        .i_cmd_full  (cmd_full)
    );

    rbh_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (front_cmd),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_cmd   (head_cmd),
        .o_empty (cmd_empty)
    );

    rbh_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (head_cmd),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .o_clearing  (clearing),
        .o_empty     (o_empty),
        .i_pop       (i_pop),
        .o_bin_index (o_bin_index),
        .o_bin_count (o_bin_count),
        .o_status    (o_status)
    );

endmodule

[hdl/rbh_front.sv]
module rbh_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  logic                i_func,
    input  logic [4:0]          i_channel,
    input  logic signed [31:0]  i_fit_chisq,
    input  logic [15:0]         i_fit_dof,
    input  logic [11:0]         i_read_bin,
    output logic                o_full,
    output rbh_pkg::t_cmd       o_cmd,
    output logic                o_cmd_push,
    input  logic                i_cmd_full
);

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_DIV  = 4'b0010,
        F_RND  = 4'b0100,
        F_PUSH = 4'b1000
    } t_fstate;

    t_fstate                    r_state, n_state;
    rbh_pkg::t_cmd              r_cmd, n_cmd;
    logic [31:0]                r_num, n_num;
    logic [23:0]                r_rem, n_rem;
    logic [23:0]                r_den, n_den;
    logic [4:0]                 r_cnt, n_cnt;

    rbh_pkg::t_cmd              cls_cmd;
    logic                       cls_div;
    logic                       accept;
    logic                       chan_oob;
    logic [rbh_pkg::ADDR_W-1:0] chan_base;
    logic [24:0]                trial;
    logic [24:0]                diff;
    logic                       ge;
    logic [24:0]                twice_rem;
    logic                       round_up;
    logic [32:0]                q_rnd;
    logic                       q_over;
    logic [rbh_pkg::BIN_W-1:0]  q_bin;

    assign accept     = i_push && (r_state == F_IDLE);
    assign o_full     = (r_state != F_IDLE);
    assign o_cmd      = r_cmd;
    assign o_cmd_push = (r_state == F_PUSH) && !i_cmd_full;

    // Classify the incoming transaction; only in-range non-negative ratios need the divider.
    always_comb begin
        chan_base = rbh_pkg::ADDR_W'(i_channel) * rbh_pkg::ADDR_W'(rbh_pkg::BINS);
        chan_oob  = 32'(i_channel) >= 32'(rbh_pkg::CHANNELS);
        cls_div        = 1'b0;
        cls_cmd.op     = rbh_pkg::OP_ZERO;
        cls_cmd.addr   = chan_base;
        cls_cmd.idx    = '0;
        cls_cmd.status = rbh_pkg::ST_IGNORED;
        if (i_func) begin
            cls_cmd.status = rbh_pkg::ST_READ;
            cls_cmd.idx    = i_read_bin;
            cls_cmd.addr   = chan_base + rbh_pkg::ADDR_W'(i_read_bin);
            if (!chan_oob && (32'(i_read_bin) < 32'(rbh_pkg::BINS))) begin
                cls_cmd.op = rbh_pkg::OP_READ;
            end
        end else if (!((i_channel == '0) || chan_oob
                       || ((i_fit_chisq == '0) && (i_fit_dof == '0)))) begin
            cls_cmd.op = rbh_pkg::OP_INC;
            if (i_fit_chisq[31]) begin
                cls_cmd.idx    = rbh_pkg::IDX_W'(rbh_pkg::BIN_NEG);
                cls_cmd.addr   = chan_base + rbh_pkg::ADDR_W'(rbh_pkg::BIN_NEG);
                cls_cmd.status = rbh_pkg::ST_NEG;
            end else if (i_fit_dof == '0) begin
                cls_cmd.idx    = rbh_pkg::IDX_W'(rbh_pkg::BIN_OVER);
                cls_cmd.addr   = chan_base + rbh_pkg::ADDR_W'(rbh_pkg::BIN_OVER);
                cls_cmd.status = rbh_pkg::ST_OVER;
            end else begin
                cls_div = 1'b1;
            end
        end
    end

    // One restoring division step per cycle; quotient bits shift into r_num.
    always_comb begin
        trial = {r_rem, r_num[31]};
        diff  = trial - {1'b0, r_den};
        ge    = trial >= {1'b0, r_den};
    end

    // Round to nearest, ties to even, then clamp to the overflow bin.
    always_comb begin
        twice_rem = {r_rem, 1'b0};
        round_up  = (twice_rem > {1'b0, r_den})
                    || ((twice_rem == {1'b0, r_den}) && r_num[0]);
        q_rnd     = {1'b0, r_num} + 33'(round_up);
        q_over    = q_rnd >= 33'(rbh_pkg::BINS);
        q_bin     = q_over ? rbh_pkg::BIN_OVER : q_rnd[rbh_pkg::BIN_W-1:0];
    end

    always_comb begin
        n_state = r_state;
        n_cmd   = r_cmd;
        n_num   = r_num;
        n_rem   = r_rem;
        n_den   = r_den;
        n_cnt   = r_cnt;
        unique case (r_state)
            F_IDLE: begin
                if (accept) begin
                    n_cmd   = cls_cmd;
                    n_num   = unsigned'(i_fit_chisq);
                    n_rem   = '0;
                    n_den   = {i_fit_dof, 8'd0};
                    n_cnt   = '0;
                    n_state = cls_div ? F_DIV : F_PUSH;
                end
            end
            F_DIV: begin
                n_rem = ge ? diff[23:0] : trial[23:0];
                n_num = {r_num[30:0], ge};
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    n_state = F_RND;
                end
            end
            F_RND: begin
                n_cmd.idx    = rbh_pkg::IDX_W'(q_bin);
                n_cmd.addr   = r_cmd.addr + rbh_pkg::ADDR_W'(q_bin);
                n_cmd.status = q_over ? rbh_pkg::ST_OVER : rbh_pkg::ST_BINNED;
                n_state      = F_PUSH;
            end
            F_PUSH: begin
                if (!i_cmd_full) begin
                    n_state = F_IDLE;
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_cmd <= n_cmd;
        r_num <= n_num;
        r_rem <= n_rem;
        r_den <= n_den;
        r_cnt <= n_cnt;
    end

endmodule

[hdl/rbh_cmd_fifo.sv]
module rbh_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  rbh_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output rbh_pkg::t_cmd o_cmd,
    output logic          o_empty
);

    rbh_pkg::t_cmd            r_q [rbh_pkg::Q_DEPTH];
    logic [rbh_pkg::Q_AW-1:0] r_wp, r_rp;
    logic [rbh_pkg::Q_AW:0]   r_cnt;
    logic                     do_push, do_pop;

    assign o_full  = (r_cnt == (rbh_pkg::Q_AW + 1)'(rbh_pkg::Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_q[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
        if (do_push) begin
            r_q[r_wp] <= i_cmd;
        end
    end

endmodule

[hdl/rbh_back.sv]
module rbh_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rbh_pkg::t_cmd               i_cmd,
    input  logic                        i_cmd_empty,
    output logic                        o_cmd_pop,
    output logic                        o_clearing,
    output logic                        o_empty,
    input  logic                        i_pop,
    output logic [rbh_pkg::IDX_W-1:0]   o_bin_index,
    output logic [31:0]                 o_bin_count,
    output logic [rbh_pkg::STAT_W-1:0]  o_status
);

    typedef enum logic [2:0] {
        B_CLEAR = 3'b001,
        B_IDLE  = 3'b010,
        B_UPD   = 3'b100
    } t_bstate;

    localparam logic [rbh_pkg::COUNT_WIDTH-1:0] COUNT_MAX = '1;

    t_bstate                          r_state;
    logic [rbh_pkg::ADDR_W-1:0]       r_clr_addr;
    rbh_pkg::t_cmd                    r_cur;
    logic [rbh_pkg::COUNT_WIDTH-1:0]  r_bin_mem [rbh_pkg::DEPTH];
    logic [rbh_pkg::COUNT_WIDTH-1:0]  r_rdata;
    logic                             r_out_valid;
    logic [rbh_pkg::IDX_W-1:0]        r_out_idx;
    logic [rbh_pkg::COUNT_WIDTH-1:0]  r_out_count;
    logic [rbh_pkg::STAT_W-1:0]       r_out_status;

    logic                             mem_we;
    logic [rbh_pkg::ADDR_W-1:0]       mem_waddr;
    logic [rbh_pkg::COUNT_WIDTH-1:0]  mem_wdata;
    logic [rbh_pkg::COUNT_WIDTH-1:0]  inc_count;
    logic [rbh_pkg::COUNT_WIDTH-1:0]  res_count;

    assign o_clearing  = (r_state == B_CLEAR);
    assign o_empty     = !r_out_valid;
    assign o_bin_index = r_out_idx;
    assign o_bin_count = 32'(r_out_count);
    assign o_status    = r_out_status;

    // A command starts only when the result register is free by the next edge.
    assign o_cmd_pop = (r_state == B_IDLE) && !i_cmd_empty && (!r_out_valid || i_pop);

    assign inc_count = (r_rdata == COUNT_MAX) ? r_rdata : r_rdata + 1'b1;

    always_comb begin
        case (r_cur.op)
            rbh_pkg::OP_INC:  res_count = inc_count;
            rbh_pkg::OP_READ: res_count = r_rdata;
            default:          res_count = '0;
        endcase
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_cur.addr;
        mem_wdata = inc_count;
        if (r_state == B_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = '0;
        end else if ((r_state == B_UPD) && (r_cur.op == rbh_pkg::OP_INC)) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_bin_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_bin_mem[i_cmd.addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                B_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == rbh_pkg::ADDR_W'(rbh_pkg::DEPTH - 1)) begin
                        r_state <= B_IDLE;
                    end
                end
                B_IDLE: begin
                    if (o_cmd_pop) begin
                        r_state <= B_UPD;
                    end
                end
                B_UPD: begin
                    r_state <= B_IDLE;
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
            if (r_state == B_UPD) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
        if (o_cmd_pop) begin
            r_cur <= i_cmd;
        end
        if (r_state == B_UPD) begin
            r_out_idx    <= r_cur.idx;
            r_out_count  <= res_count;
            r_out_status <= r_cur.status;
        end
    end

endmodule

[hdl/rbh_checker.sv]
module rbh_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_push,
    input logic                o_full,
    input logic                o_empty,
    input logic                i_pop,
    input logic [11:0]         o_bin_index,
    input logic [31:0]         o_bin_count,
    input logic [2:0]          o_status
);

    // Reset starts the clearing pass and drops any pending result.
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_full && o_empty))
        else $error("queue state wrong after reset");

    // The front takes one transaction at a time.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !o_full) |=> o_full)
        else $error("second transaction accepted while the first was in progress");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> (!o_empty && $stable(o_bin_index)
                                  && $stable(o_bin_count) && $stable(o_status)))
        else $error("waiting result changed before it was taken");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> (o_status <= rbh_pkg::ST_READ))
        else $error("undefined status code");

    a_ignored_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && (o_status == rbh_pkg::ST_IGNORED))
        |-> ((o_bin_index == '0) && (o_bin_count == '0)))
        else $error("ignored item returned a nonzero bin or count");

endmodule

bind ratio_binned_histogram rbh_checker u_rbh_checker (.*);
